// ----- rtl/core/lcs_pkg.sv -----
// Package for the LCS length engine: opcodes, command types and sizing constants.
// Used by every module in rtl/core except lcs_ram; depends on nothing.
package lcs_pkg;

    localparam int MAX_LEN_DEFAULT = 256;
    localparam int SYM_W           = 8;
    localparam int LEN_W           = 9;
    localparam int LENGTH_MAX      = 511;
    localparam int FIFO_DEPTH      = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SWEEP  = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_SWEEP  = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [SYM_W-1:0]  symbol;
    } t_cmd;

endpackage

// ----- rtl/core/lcs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/lcs_front.sv -----
// Front end: accepts input items, decodes the opcode and holds one command for the queue.
// Depends on lcs_pkg.
module lcs_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_op,
    input  logic [lcs_pkg::SYM_W-1:0] i_symbol,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_ready,
    output lcs_pkg::t_cmd             o_cmd
);

    logic          r_valid;
    logic          n_valid;
    lcs_pkg::t_cmd r_cmd;
    lcs_pkg::t_cmd dec_cmd;
    logic          dec_ok;
    logic          accept;
    logic          pushed;

    assign o_ready = !r_valid || i_cmd_ready;
    assign accept  = i_valid && o_ready;
    assign pushed  = r_valid && i_cmd_ready;

    always_comb begin
        dec_ok         = 1'b1;
        dec_cmd.symbol = i_symbol;
        dec_cmd.kind   = lcs_pkg::KIND_LOAD;
        unique case (i_op)
            lcs_pkg::OP_LOAD:   dec_cmd.kind = lcs_pkg::KIND_LOAD;
            lcs_pkg::OP_SWEEP:  dec_cmd.kind = lcs_pkg::KIND_SWEEP;
            lcs_pkg::OP_FINISH: dec_cmd.kind = lcs_pkg::KIND_FINISH;
            default:            dec_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_valid = (r_valid && !pushed) || (accept && dec_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept && dec_ok) begin
            r_cmd <= dec_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ----- rtl/core/lcs_cmd_fifo.sv -----
// Short command queue between the front end and the row engine.
// Depends on lcs_pkg.
module lcs_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  lcs_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output lcs_pkg::t_cmd o_pop_cmd
);

    localparam int DEPTH = lcs_pkg::FIFO_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    lcs_pkg::t_cmd r_slot [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;
    logic [CW-1:0] n_count;
    logic          push;
    logic          pop;

    assign o_push_ready = r_count != CW'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_slot[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

endmodule

// ----- rtl/core/lcs_back.sv -----
// Row engine: stores the symbol buffer, sweeps the score row one cell per cycle,
// and emits the result on finish. Depends on lcs_pkg and lcs_ram.
module lcs_back #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  lcs_pkg::t_cmd             i_cmd,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [lcs_pkg::LEN_W-1:0] o_length,
    output logic                      o_overflow
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SWEEP  = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [CW-1:0]             r_fill;
    logic [CW-1:0]             n_fill;
    logic                      r_trunc;
    logic                      n_trunc;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [AW-1:0]             r_j;
    logic [AW-1:0]             n_j;
    logic [CW-1:0]             r_diag;
    logic [CW-1:0]             r_left;
    logic [lcs_pkg::SYM_W-1:0] r_sym;
    logic [lcs_pkg::LEN_W-1:0] r_length;
    logic                      r_overflow;

    logic                      take;
    logic [CW-1:0]             count_m1;
    logic [AW-1:0]             rd_addr;
    logic                      sym_we;
    logic [lcs_pkg::SYM_W-1:0] sym_rd;
    logic [CW-1:0]             row_rd;
    logic                      row_we;
    logic [CW-1:0]             above;
    logic [CW-1:0]             cell_val;
    logic [CW-1:0]             fin_cell;
    logic                      last;
    logic                      start_sweep;

    assign count_m1 = r_count - 1'b1;
    assign o_cmd_ready = (r_state == S_IDLE)
                      && !(i_cmd.kind == lcs_pkg::KIND_FINISH && r_out_valid);
    assign take        = i_cmd_valid && o_cmd_ready;
    assign sym_we      = take && i_cmd.kind == lcs_pkg::KIND_LOAD
                      && r_count < CW'(MAX_LEN);
    assign start_sweep = take && i_cmd.kind == lcs_pkg::KIND_SWEEP && r_count != '0;

    assign above    = (CW'(r_j) < r_fill) ? row_rd : '0;
    assign cell_val = (sym_rd == r_sym) ? r_diag + 1'b1
                    : ((above > r_left) ? above : r_left);
    assign last     = CW'(r_j) == count_m1;
    assign row_we   = r_state == S_SWEEP;
    assign fin_cell = (r_count != '0 && count_m1 < r_fill) ? row_rd : '0;

    always_comb begin
        rd_addr = '0;
        if (r_state == S_SWEEP) begin
            rd_addr = r_j + 1'b1;
        end else if (i_cmd.kind == lcs_pkg::KIND_FINISH) begin
            rd_addr = count_m1[AW-1:0];
        end
    end

    lcs_ram #(
        .WIDTH (lcs_pkg::SYM_W),
        .DEPTH (MAX_LEN)
    ) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_cmd.symbol),
        .i_raddr (rd_addr),
        .o_rdata (sym_rd)
    );

    lcs_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_LEN)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_j),
        .i_wdata (cell_val),
        .i_raddr (rd_addr),
        .o_rdata (row_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_fill      = r_fill;
        n_trunc     = r_trunc;
        n_j         = r_j;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_cmd.kind)
                        lcs_pkg::KIND_LOAD: begin
                            if (sym_we) begin
                                n_count = r_count + 1'b1;
                            end else begin
                                n_trunc = 1'b1;
                            end
                        end
                        lcs_pkg::KIND_SWEEP: begin
                            if (start_sweep) begin
                                n_j     = '0;
                                n_state = S_SWEEP;
                            end
                        end
                        lcs_pkg::KIND_FINISH: n_state = S_FINISH;
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                n_j = r_j + 1'b1;
                if (last) begin
                    n_fill  = r_count;
                    n_state = S_IDLE;
                end
            end
            S_FINISH: begin
                n_out_valid = 1'b1;
                n_count     = '0;
                n_fill      = '0;
                n_trunc     = 1'b0;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fill      <= '0;
            r_trunc     <= 1'b0;
            r_out_valid <= 1'b0;
            r_j         <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_trunc     <= n_trunc;
            r_out_valid <= n_out_valid;
            r_j         <= n_j;
        end
        if (start_sweep) begin
            r_sym  <= i_cmd.symbol;
            r_diag <= '0;
            r_left <= '0;
        end else if (r_state == S_SWEEP) begin
            r_diag <= above;
            r_left <= cell_val;
        end
        if (r_state == S_FINISH) begin
            r_length   <= (fin_cell > lcs_pkg::LENGTH_MAX)
                        ? lcs_pkg::LEN_W'(lcs_pkg::LENGTH_MAX)
                        : lcs_pkg::LEN_W'(fin_cell);
            r_overflow <= r_trunc;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_length   = r_length;
    assign o_overflow = r_overflow;

endmodule

// ----- rtl/core/lcs_length_engine.sv -----
// LCS length engine top level: front end, command queue and row engine.
// A sweep walks the score-row RAM one cell per cycle over the stored symbols (up to a full
// 256-symbol buffer), and the row engine takes no other command while it runs; a 4-entry
// queue lets input keep flowing while a sweep runs, until the queue fills.
// Op 3 is accepted and dropped. Depends on lcs_pkg, lcs_front, lcs_cmd_fifo, lcs_back.
module lcs_length_engine #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_op,
    input  logic [lcs_pkg::SYM_W-1:0] i_symbol,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [lcs_pkg::LEN_W-1:0] o_length,
    output logic                      o_overflow
);

    logic          w_fr_valid;
    logic          w_fr_ready;
    lcs_pkg::t_cmd w_fr_cmd;
    logic          w_q_valid;
    logic          w_bk_ready;
    lcs_pkg::t_cmd w_q_cmd;

    lcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_op        (i_op),
        .i_symbol    (i_symbol),
        .o_cmd_valid (w_fr_valid),
        .i_cmd_ready (w_fr_ready),
        .o_cmd       (w_fr_cmd)
    );

    lcs_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fr_valid),
        .o_push_ready (w_fr_ready),
        .i_push_cmd   (w_fr_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_bk_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    lcs_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_bk_ready),
        .i_cmd       (w_q_cmd),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_length    (o_length),
        .o_overflow  (o_overflow)
    );

`ifndef SYNTHESIS
    a_finish_waits_for_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_valid && w_bk_ready && w_q_cmd.kind == lcs_pkg::KIND_FINISH && o_out_valid))
        else $error("finish popped while a result is pending");

    a_sweep_reaches_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_op == lcs_pkg::OP_SWEEP) |=> w_fr_valid)
        else $error("accepted sweep not held by front end");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid)
        |-> $past(w_q_valid && w_bk_ready && w_q_cmd.kind == lcs_pkg::KIND_FINISH, 2))
        else $error("result raised without a finish transfer");
`endif

endmodule

// ----- tb/lcs_length_engine_test.sv -----
// Self-checking testbench for lcs_length_engine: directed table, then random load/sweep/finish
// sequences, checked against a row-based LCS predictor or a table row's own result. Depends on lcs_pkg.
module lcs_length_engine_test;

    localparam int         BUF_LEN   = lcs_pkg::MAX_LEN_DEFAULT;
    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam int         HOLD_LEN  = 2000;
    localparam int         DRAIN_LEN = 1300;

    typedef struct packed {
        logic [lcs_pkg::LEN_W-1:0] len;
        logic                      ovf;
    } t_lcs_result;

    typedef struct {
        logic [1:0]                op;
        logic [lcs_pkg::SYM_W-1:0] sym;
        int                        reps;
        bit                        typed;
        logic [lcs_pkg::LEN_W-1:0] len;
        logic                      ovf;
    } t_plan_row;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_op        = lcs_pkg::OP_LOAD;
    logic [lcs_pkg::SYM_W-1:0] i_symbol    = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [lcs_pkg::LEN_W-1:0] o_length;
    logic                      o_overflow;

    logic [lcs_pkg::SYM_W-1:0] held_sym [BUF_LEN];
    logic [lcs_pkg::LEN_W-1:0] row_score [BUF_LEN];
    int                        held_count = 0;
    logic                      held_trunc = 1'b0;

    t_lcs_result      pending_lengths[$];
    t_lcs_result      due_now;
    int               errors     = 0;
    int               items_sent = 0;
    bit               burst      = 1'b0;
    bit               hold_out   = 1'b0;

    t_plan_row plan [20] = '{
        '{lcs_pkg::OP_FINISH, 8'h00, 1,   1'b1, 9'd0,   1'b0},
        '{lcs_pkg::OP_SWEEP,  8'h41, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_FINISH, 8'hFF, 1,   1'b1, 9'd0,   1'b0},
        '{lcs_pkg::OP_LOAD,   8'h00, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_LOAD,   8'hFF, 1,   1'b0, 9'd0,   1'b0},
        '{OP_SPARE,           8'hAA, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_SWEEP,  8'hFF, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_SWEEP,  8'h00, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_FINISH, 8'h00, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_LOAD,   8'h41, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_SWEEP,  8'h41, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_LOAD,   8'h42, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_SWEEP,  8'h42, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_FINISH, 8'h00, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_LOAD,   8'h5A, 257, 1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_SWEEP,  8'h5A, 256, 1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_FINISH, 8'h00, 1,   1'b1, 9'd256, 1'b1},
        '{lcs_pkg::OP_LOAD,   8'h55, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_SWEEP,  8'hAA, 1,   1'b0, 9'd0,   1'b0},
        '{lcs_pkg::OP_FINISH, 8'h00, 1,   1'b0, 9'd0,   1'b0}
    };

    lcs_length_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_symbol    (i_symbol),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_length    (o_length),
        .o_overflow  (o_overflow)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void sweep_lcs_row(logic [lcs_pkg::SYM_W-1:0] sym);
        logic [lcs_pkg::LEN_W-1:0] diag;
        logic [lcs_pkg::LEN_W-1:0] left;
        logic [lcs_pkg::LEN_W-1:0] above;
        logic [lcs_pkg::LEN_W-1:0] val;
        diag = '0;
        left = '0;
        for (int j = 0; j < held_count; j++) begin
            above = row_score[j];
            if (held_sym[j] == sym) val = diag + 1'b1;
            else val = (above > left) ? above : left;
            row_score[j] = val;
            diag = above;
            left = val;
        end
    endfunction

    function automatic void track_lcs(logic [1:0] op, logic [lcs_pkg::SYM_W-1:0] sym,
                                      bit typed, logic [lcs_pkg::LEN_W-1:0] tlen,
                                      logic tovf);
        t_lcs_result res;
        int          len;
        case (op)
            lcs_pkg::OP_LOAD: begin
                if (held_count < BUF_LEN) begin
                    held_sym[held_count] = sym;
                    held_count++;
                end else begin
                    held_trunc = 1'b1;
                end
            end
            lcs_pkg::OP_SWEEP: sweep_lcs_row(sym);
            lcs_pkg::OP_FINISH: begin
                len = (held_count > 0) ? int'(row_score[held_count-1]) : 0;
                if (len > lcs_pkg::LENGTH_MAX) len = lcs_pkg::LENGTH_MAX;
                res.len = typed ? tlen : lcs_pkg::LEN_W'(len);
                res.ovf = typed ? tovf : held_trunc;
                pending_lengths.push_back(res);
                for (int j = 0; j < BUF_LEN; j++) row_score[j] = '0;
                held_count = 0;
                held_trunc = 1'b0;
            end
            default: ;
        endcase
    endfunction

    task automatic put_item(logic [1:0] op, logic [lcs_pkg::SYM_W-1:0] sym,
                            bit typed = 1'b0, logic [lcs_pkg::LEN_W-1:0] tlen = '0,
                            logic tovf = 1'b0);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_symbol   <= sym;
        do @(posedge i_clk); while (!o_in_ready);
        track_lcs(op, sym, typed, tlen, tovf);
        if (op != OP_SPARE) items_sent++;
    endtask

    task automatic run_sequence(int n_load, int n_sweep, bit tidy);
        bit                        narrow;
        logic [lcs_pkg::SYM_W-1:0] base;
        logic [lcs_pkg::SYM_W-1:0] sym;
        narrow = ($urandom_range(0, 3) != 0);
        base   = lcs_pkg::SYM_W'($urandom_range(0, 255));
        burst  = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n_load + n_sweep; k++) begin
            sym = narrow ? (base ^ lcs_pkg::SYM_W'($urandom_range(0, 3)))
                         : lcs_pkg::SYM_W'($urandom_range(0, 255));
            if (!tidy && $urandom_range(0, 29) == 0)
                put_item(OP_SPARE, lcs_pkg::SYM_W'($urandom_range(0, 255)));
            if (k < n_load) begin
                put_item(lcs_pkg::OP_LOAD, sym);
            end else begin
                if (!tidy && $urandom_range(0, 19) == 0)
                    put_item(lcs_pkg::OP_LOAD, sym ^ 8'h01);
                put_item(lcs_pkg::OP_SWEEP, sym);
            end
        end
        if (tidy || $urandom_range(0, 19) != 0)
            put_item(lcs_pkg::OP_FINISH, lcs_pkg::SYM_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int seq;
        int r;
        int n_load;
        int n_sweep;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            for (int k = 0; k < plan[i].reps; k++)
                put_item(plan[i].op, plan[i].sym, plan[i].typed, plan[i].len, plan[i].ovf);
        end

        seq = 0;
        while (items_sent < 1450) begin
            if (seq == 2) hold_out = 1'b1;
            if (seq == 12) begin
                i_in_valid <= 1'b0;
                wait (pending_lengths.size() == 0);
                @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (seq >= 2 && seq < 10) begin
                n_load  = $urandom_range(1, 3);
                n_sweep = $urandom_range(1, 2);
            end else if (r < 80) begin
                n_load  = $urandom_range(1, 16);
                n_sweep = $urandom_range(0, 24);
            end else if (r < 92) begin
                n_load  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 64);
                n_sweep = $urandom_range(0, 12);
            end else if (r < 97) begin
                n_load  = $urandom_range(200, 256);
                n_sweep = $urandom_range(1, 6);
            end else begin
                n_load  = $urandom_range(257, 270);
                n_sweep = $urandom_range(1, 4);
            end
            run_sequence(n_load, n_sweep, r < 70);
            seq++;
        end
        burst = 1'b0;
        put_item(lcs_pkg::OP_FINISH, 8'h00);
        i_in_valid <= 1'b0;

        wait (pending_lengths.size() == 0);
        repeat (DRAIN_LEN) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        int on_len;
        int stall;
        wait (i_rst_n);
        forever begin
            if (hold_out) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_out = 1'b0;
            end
            on_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(40, 150);
            stall  = pick_gap();
            i_out_ready <= 1'b1;
            repeat (on_len) @(posedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_lengths.size() == 0) begin
                $display("%0t: unexpected result length %0d overflow %0d",
                         $time, o_length, o_overflow);
                errors++;
            end else begin
                due_now = pending_lengths.pop_front();
                if (o_length !== due_now.len) begin
                    $display("%0t: length expected %0d got %0d", $time, due_now.len, o_length);
                    errors++;
                end
                if (o_overflow !== due_now.ovf) begin
                    $display("%0t: overflow expected %0d got %0d",
                             $time, due_now.ovf, o_overflow);
                    errors++;
                end
            end
        end
    end

endmodule

// ----- files.f -----
rtl/core/lcs_pkg.sv
rtl/core/lcs_ram.sv
rtl/core/lcs_front.sv
rtl/core/lcs_cmd_fifo.sv
rtl/core/lcs_back.sv
rtl/core/lcs_length_engine.sv
tb/lcs_length_engine_test.sv
